@@ src/replica_health_table_unit_defines.svh @@
// ---------------------------------------------------------------------------
// Replica health table assertion macros
// Shared concurrent assertion forms for the replica health table unit.
// ---------------------------------------------------------------------------
`ifndef REPLICA_HEALTH_TABLE_UNIT_DEFINES_SVH
`define REPLICA_HEALTH_TABLE_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define RHT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("replica health table assertion failed");

// next-cycle implication, checked out of reset
`define RHT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("replica health table assertion failed");

`endif

@@ src/rht_pkg.sv @@
// ---------------------------------------------------------------------------
// Replica health table package
// Codes, state type and controller/datapath interface structs.
// ---------------------------------------------------------------------------
package rht_pkg;

   localparam int SlotsDefault = 8;

   typedef enum logic [2:0] {
      MODE_ADD     = 3'd0,
      MODE_REMOVE  = 3'd1,
      MODE_REPL    = 3'd2,
      MODE_BEAT    = 3'd3,
      MODE_SWEEP   = 3'd4,
      MODE_BEST    = 3'd5,
      MODE_PROMOTE = 3'd6,
      MODE_QUERY   = 3'd7
   } mode_type;

   typedef enum logic [1:0] {
      HEALTH_ACTIVE       = 2'd0,
      HEALTH_CATCHING     = 2'd1,
      HEALTH_STALE        = 2'd2,
      HEALTH_DISCONNECTED = 2'd3
   } health_type;

   localparam logic [1:0] CSR_MAX_MEMBERS = 2'd0;
   localparam logic [1:0] CSR_STALENESS   = 2'd1;
   localparam logic [1:0] CSR_CATCHUP     = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_APPLY
   } state_type;

   typedef struct packed {
      logic load;   // latch the word and clear the walk results
      logic rd_en;  // read one slot at the walk address
      logic apply;  // commit the operation and load the result register
   } cmd_type;

   typedef struct packed {
      logic out_hold; // result register full and not being taken
   } status_type;

endpackage

@@ src/rht_ctrl.sv @@
// ---------------------------------------------------------------------------
// Replica health table controller
// Sequences load, slot walk, pipeline drain and commit for one word.
// ---------------------------------------------------------------------------
module rht_ctrl
   import rht_pkg::*;
#(
   parameter int SLOTS = SlotsDefault
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  status_type               status,
   output cmd_type                  cmd,
   output logic [$clog2(SLOTS)-1:0] rd_addr
);

   localparam int AW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 2);

   state_type     state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign rd_addr = cnt_ff[AW-1:0];

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cnt_in     = '0;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            cmd.rd_en = (cnt_ff < CW'(SLOTS));
            cnt_in    = cnt_ff + CW'(1);
            // drain the compare pipeline after the last read
            if (cnt_ff == CW'(SLOTS + 1)) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            if (!status.out_hold) begin
               cmd.apply = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

@@ src/rht_datapath.sv @@
// ---------------------------------------------------------------------------
// Replica health table datapath
// Slot storage, walk pipeline, accumulators, commit and result register.
// ---------------------------------------------------------------------------
module rht_datapath
   import rht_pkg::*;
#(
   parameter int SLOTS = SlotsDefault
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   input  logic [$clog2(SLOTS)-1:0] rd_addr,
   output status_type               status,
   input  logic [2:0]               req_mode,
   input  logic [15:0]              req_node_id,
   input  logic [63:0]              req_index_value,
   input  logic [63:0]              req_now_us,
   input  logic                     csr_we,
   input  logic [1:0]               csr_index,
   input  logic [31:0]              csr_wdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [87:0]              rsp_tdata
);

   localparam int AW = $clog2(SLOTS);

   // configuration
   logic [3:0]  max_ff;
   logic [31:0] stale_ff, catch_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff   <= 4'd8;
         stale_ff <= 32'd1000000;
         catch_ff <= 32'd100;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_MEMBERS: max_ff   <= csr_wdata[3:0];
            CSR_STALENESS:   stale_ff <= csr_wdata;
            CSR_CATCHUP:     catch_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // latched word
   mode_type    mode_ff;
   logic [15:0] node_ff;
   logic [63:0] idx_ff, now_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= mode_type'(req_mode);
         node_ff <= req_node_id;
         idx_ff  <= req_index_value;
         now_ff  <= req_now_us;
      end
   end

   // slot storage
   logic [15:0] mem_node   [SLOTS];
   logic [63:0] mem_ridx   [SLOTS];
   logic [63:0] mem_rtime  [SLOTS];
   logic [63:0] mem_btime  [SLOTS];
   logic [1:0]  mem_health [SLOTS];
   logic [SLOTS-1:0] used_ff, used_in;
   logic [3:0]  count_ff, count_in;

   logic [15:0] rd_node_ff;
   logic [63:0] rd_ridx_ff, rd_rtime_ff, rd_btime_ff;
   logic [1:0]  rd_health_ff;

   // write port controls
   logic          node_we, ridx_we, rtime_we, btime_we, health_we;
   logic [AW-1:0] node_wa, ridx_wa, rtime_wa, btime_wa, health_wa;
   logic [63:0]   ridx_wd;
   logic [1:0]    health_wd;

   always_ff @(posedge clock) begin
      if (node_we)   mem_node[node_wa]     <= node_ff;
      if (ridx_we)   mem_ridx[ridx_wa]     <= ridx_wd;
      if (rtime_we)  mem_rtime[rtime_wa]   <= now_ff;
      if (btime_we)  mem_btime[btime_wa]   <= now_ff;
      if (health_we) mem_health[health_wa] <= health_wd;
      if (cmd.rd_en) begin
         rd_node_ff   <= mem_node[rd_addr];
         rd_ridx_ff   <= mem_ridx[rd_addr];
         rd_rtime_ff  <= mem_rtime[rd_addr];
         rd_btime_ff  <= mem_btime[rd_addr];
         rd_health_ff <= mem_health[rd_addr];
      end
   end

   // walk pipeline: read, differences, evaluate
   logic          p1_valid_ff, p2_valid_ff;
   logic [AW-1:0] p1_addr_ff, p2_addr_ff;
   logic [15:0]   p2_node_ff;
   logic [63:0]   p2_ridx_ff, p2_bdiff_ff, p2_rdiff_ff, p2_lag_ff;
   logic [1:0]    p2_health_ff;
   logic          p2_bzero_ff, p2_ahead_ff;
   logic [64:0]   lag_full;

   assign lag_full = {1'b0, idx_ff} - {1'b0, rd_ridx_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= cmd.rd_en;
         p2_valid_ff <= p1_valid_ff;
      end
      p1_addr_ff   <= rd_addr;
      p2_addr_ff   <= p1_addr_ff;
      p2_node_ff   <= rd_node_ff;
      p2_ridx_ff   <= rd_ridx_ff;
      p2_health_ff <= rd_health_ff;
      p2_bzero_ff  <= (rd_btime_ff == 64'd0);
      p2_bdiff_ff  <= now_ff - rd_btime_ff;
      p2_rdiff_ff  <= now_ff - rd_rtime_ff;
      p2_lag_ff    <= lag_full[63:0];
      p2_ahead_ff  <= lag_full[64];
   end

   // accumulators
   logic          found_ff, free_ff, best_ok_ff;
   logic [AW-1:0] found_addr_ff, free_addr_ff;
   logic [63:0]   found_ridx_ff, best_idx_ff;
   logic [1:0]    found_health_ff;
   logic [15:0]   best_node_ff;

   logic       p2_used, p2_match, p2_stale, p2_disc, p2_behind, p2_cand;
   logic [1:0] sweep_class;

   always_comb begin
      p2_used   = used_ff[p2_addr_ff];
      p2_match  = p2_valid_ff && p2_used && (node_ff != 16'd0) && (p2_node_ff == node_ff);
      p2_disc   = p2_bzero_ff || (p2_bdiff_ff > {31'd0, stale_ff, 1'b0});
      p2_stale  = p2_rdiff_ff > {32'd0, stale_ff};
      p2_behind = !p2_ahead_ff && (p2_lag_ff > {32'd0, catch_ff});
      priority if (p2_disc)   sweep_class = HEALTH_DISCONNECTED;
      else if (p2_stale)      sweep_class = HEALTH_STALE;
      else if (p2_behind)     sweep_class = HEALTH_CATCHING;
      else                    sweep_class = HEALTH_ACTIVE;
      p2_cand = p2_valid_ff && p2_used && (mode_ff == MODE_BEST) &&
                (p2_health_ff == HEALTH_ACTIVE) && !p2_stale;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         found_ff   <= 1'b0;
         free_ff    <= 1'b0;
         best_ok_ff <= 1'b0;
      end else begin
         if (p2_match && !found_ff) begin
            found_ff        <= 1'b1;
            found_addr_ff   <= p2_addr_ff;
            found_ridx_ff   <= p2_ridx_ff;
            found_health_ff <= p2_health_ff;
         end
         if (p2_valid_ff && !p2_used && !free_ff) begin
            free_ff      <= 1'b1;
            free_addr_ff <= p2_addr_ff;
         end
         if (p2_cand && (!best_ok_ff || p2_ridx_ff > best_idx_ff)) begin
            best_ok_ff   <= 1'b1;
            best_node_ff <= p2_node_ff;
            best_idx_ff  <= p2_ridx_ff;
         end
      end
   end

   // commit
   logic        ok, add_go, rel_go, promo_lag_ok;
   logic [1:0]  status_val;
   logic [15:0] bnode;
   logic [63:0] bindex;
   logic [64:0] promo_full;

   assign promo_full = {1'b0, idx_ff} - {1'b0, found_ridx_ff};

   always_comb begin
      promo_lag_ok = promo_full[64] || (promo_full[63:0] <= {32'd0, catch_ff});
      add_go     = (node_ff != 16'd0) && !found_ff && (count_ff < max_ff) && free_ff;
      rel_go     = 1'b0;
      ok         = 1'b0;
      status_val = 2'd0;
      bnode      = 16'd0;
      bindex     = 64'd0;
      node_we    = 1'b0;
      ridx_we    = 1'b0;
      rtime_we   = 1'b0;
      btime_we   = 1'b0;
      health_we  = 1'b0;
      node_wa    = free_addr_ff;
      ridx_wa    = free_addr_ff;
      rtime_wa   = free_addr_ff;
      btime_wa   = free_addr_ff;
      health_wa  = free_addr_ff;
      ridx_wd    = 64'd0;
      health_wd  = HEALTH_CATCHING;
      used_in    = used_ff;
      count_in   = count_ff;
      // sweep writes each occupied slot's class as it leaves the pipeline
      if (p2_valid_ff && p2_used && mode_ff == MODE_SWEEP) begin
         health_we = 1'b1;
         health_wa = p2_addr_ff;
         health_wd = sweep_class;
      end
      if (cmd.apply) begin
         unique case (mode_ff)
            MODE_ADD: begin
               if (add_go) begin
                  ok        = 1'b1;
                  node_we   = 1'b1;
                  ridx_we   = 1'b1;
                  rtime_we  = 1'b1;
                  btime_we  = 1'b1;
                  health_we = 1'b1;
                  used_in[free_addr_ff] = 1'b1;
                  count_in  = count_ff + 4'd1;
               end
            end
            MODE_REMOVE: begin
               rel_go = found_ff;
            end
            MODE_REPL: begin
               if (found_ff) begin
                  ok       = 1'b1;
                  ridx_we  = 1'b1;
                  rtime_we = 1'b1;
                  ridx_wa  = found_addr_ff;
                  rtime_wa = found_addr_ff;
                  ridx_wd  = idx_ff;
               end
            end
            MODE_BEAT: begin
               if (found_ff) begin
                  ok       = 1'b1;
                  btime_we = 1'b1;
                  btime_wa = found_addr_ff;
               end
            end
            MODE_SWEEP: ok = 1'b1;
            MODE_BEST: begin
               ok     = best_ok_ff;
               bnode  = best_ok_ff ? best_node_ff : 16'd0;
               bindex = best_ok_ff ? best_idx_ff : 64'd0;
            end
            MODE_PROMOTE: begin
               rel_go = found_ff && promo_lag_ok;
            end
            MODE_QUERY: begin
               if (found_ff) begin
                  ok         = 1'b1;
                  status_val = found_health_ff;
               end
            end
            default: ;
         endcase
         if (rel_go) begin
            ok = 1'b1;
            used_in[found_addr_ff] = 1'b0;
            count_in = count_ff - 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= '0;
         count_ff <= 4'd0;
      end else begin
         used_ff  <= used_in;
         count_ff <= count_in;
      end
   end

   // result register
   logic        rsp_valid_ff;
   logic [87:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.apply) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.apply) begin
         rsp_data_ff <= {1'b0, count_in, bindex, bnode, status_val, ok};
      end
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_data_ff;
   assign status.out_hold = rsp_valid_ff && !rsp_tready;

endmodule

@@ src/replica_health_table_unit.sv @@
// ---------------------------------------------------------------------------
// Replica health table unit
// Fixed table of replica slots keyed by node id, with add, remove,
// progress, heartbeat, sweep, best-for-read, promote and query operations.
// ---------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  req_     | in        | tvalid/tready       | tuser mode, tdata node/index/time
//  rsp_     | out       | tvalid/tready       | tdata ok/status/best/count
//  csr_     | in        | we, no wait         | index, 32-bit wdata
//
//  Between one acceptance and the next, each word is loaded, the slot
//  memories are read SLOTS times, the compare pipeline drains and the word
//  commits; the result word is registered at commit. One word is in work at
//  a time.
//  Reset is synchronous, clears slot occupancy and the count, resets config.
//  A result waiting in the output register does not block the next word;
//  commit waits only while that register is full and not being taken.
// ---------------------------------------------------------------------------
`include "replica_health_table_unit_defines.svh"

module replica_health_table_unit
   import rht_pkg::*;
#(
   parameter int SLOTS = SlotsDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [2:0]   req_tuser,   // mode
   input  logic [143:0] req_tdata,   // node_id, index_value, now_us
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [87:0]  rsp_tdata,   // ok, member_status, best_node, best_index, member_count
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   cmd_type                  cmd;
   status_type               status;
   logic [$clog2(SLOTS)-1:0] rd_addr;

   // sequence the walk
   rht_ctrl #(.SLOTS(SLOTS)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd),
      .rd_addr    (rd_addr)
   );

   // hold slots, evaluate and commit
   rht_datapath #(.SLOTS(SLOTS)) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .rd_addr         (rd_addr),
      .status          (status),
      .req_mode        (req_tuser),
      .req_node_id     (req_tdata[15:0]),
      .req_index_value (req_tdata[79:16]),
      .req_now_us      (req_tdata[143:80]),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata)
   );

   // busy for the whole walk after taking a word
   `RHT_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)
   // a chosen node only comes with success
   `RHT_ASSERT_SAME(a_best_implies_ok, clock, reset, rsp_tvalid && (rsp_tdata[18:3] != 16'd0), rsp_tdata[0])
   // a reported health only comes with a found slot
   `RHT_ASSERT_SAME(a_status_implies_ok, clock, reset, rsp_tvalid && (rsp_tdata[2:1] != 2'd0), rsp_tdata[0])

endmodule
